// ===== hdl/hspd_pkg.sv =====
// Shared types, widths and constants of the headway spacing PID drive unit.
package hspd_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int DIST_W     = 16;
    localparam int SPEED_W    = 15;
    localparam int GAIN_W     = 16;
    localparam int HEADWAY_W  = 11;
    localparam int GAP_W      = 14;
    localparam int LEVEL_W    = 9;
    localparam int ERR_W      = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier: signed A operand by a B operand that carries
    // unsigned values zero extended.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADWAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STANDGAP = 3'd4;

    localparam logic signed [ERR_W-1:0] ERR_MAX = 19'sd262143;
    localparam logic signed [ERR_W-1:0] ERR_MIN = -19'sd262144;

    // Division of a 19-bit magnitude by ten: multiply by the rounded-up
    // reciprocal and drop DIV10_SHIFT bits. Exact over the whole range.
    localparam logic [ERR_W-1:0] DIV10_MAGIC = 19'd419431;
    localparam int DIV10_SHIFT = 22;
    localparam int QUO_W       = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 9'd256;

    typedef enum logic [2:0] {
        MUL_HEAD,
        MUL_RECIP,
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD,
        SUM_ADD
    } sum_op_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     err_we;
        logic     deriv_we;
        logic     int_we;
        sum_op_t  sum_op;
        logic     out_we;
    } cmd_t;

endpackage

// ===== hdl/hspd_ctrl.sv =====
// Sequencer that walks one item through the shared-multiplier datapath.
module hspd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hspd_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ERR,
        ST_RECIP,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = hspd_pkg::MUL_HEAD;
        cmd.sum_op   = hspd_pkg::SUM_HOLD;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hspd_pkg::MUL_HEAD;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err_we = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = hspd_pkg::MUL_RECIP;
                cmd.deriv_we = 1'b1;
                state_next   = ST_PROP;
            end
            ST_PROP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hspd_pkg::MUL_PROP;
                cmd.int_we  = 1'b1;
                state_next  = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hspd_pkg::MUL_INTEG;
                cmd.sum_op  = hspd_pkg::SUM_LOAD;
                state_next  = ST_DERIV;
            end
            ST_DERIV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hspd_pkg::MUL_DERIV;
                cmd.sum_op  = hspd_pkg::SUM_ADD;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_op = hspd_pkg::SUM_ADD;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_we     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/hspd_dp.sv =====
// Datapath: configuration registers, shared multiplier, loop state and outputs.
module hspd_dp
#(
    parameter int FRAC_BITS = hspd_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hspd_pkg::cmd_t                       cmd,
    input  logic                                 cfg_we,
    input  logic [hspd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hspd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [hspd_pkg::DIST_W-1:0]          lead_distance,
    input  logic signed [hspd_pkg::SPEED_W-1:0]  closing_speed,
    output logic [hspd_pkg::LEVEL_W-1:0]         throttle_level,
    output logic [hspd_pkg::LEVEL_W-1:0]         brake_level
);

    localparam int ERR_W      = hspd_pkg::ERR_W;
    localparam int PROD_W     = hspd_pkg::PROD_W;
    localparam int INT_W      = $clog2((10 << FRAC_BITS) + 1) + 1;
    localparam int INC_W      = hspd_pkg::QUO_W + 1;
    localparam int INT_SUM_W  = ((INT_W > INC_W) ? INT_W : INC_W) + 1;
    localparam int DER_W      = ERR_W + 5;
    localparam int OUT_SHIFT  = 2 * FRAC_BITS - 8;
    localparam logic signed [INT_SUM_W-1:0] INT_LIMIT = INT_SUM_W'(10 << FRAC_BITS);
    localparam logic signed [ERR_W-1:0]     ERR_HALF  = ERR_W'(1 << (FRAC_BITS - 1));

    logic [hspd_pkg::GAIN_W-1:0]    gain_p_reg;
    logic [hspd_pkg::GAIN_W-1:0]    gain_i_reg;
    logic [hspd_pkg::GAIN_W-1:0]    gain_d_reg;
    logic [hspd_pkg::HEADWAY_W-1:0] headway_reg;
    logic [hspd_pkg::GAP_W-1:0]     gap_reg;

    logic [hspd_pkg::DIST_W-1:0]          dist_reg;
    logic signed [hspd_pkg::SPEED_W-1:0]  speed_reg;
    logic signed [ERR_W-1:0]              error_reg;
    logic signed [ERR_W-1:0]              last_error_reg;
    logic signed [DER_W-1:0]              deriv_reg;
    logic signed [INT_W-1:0]              integral_reg;
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [PROD_W-1:0]             pid_sum_reg;
    logic [hspd_pkg::LEVEL_W-1:0]         throttle_reg;
    logic [hspd_pkg::LEVEL_W-1:0]         brake_reg;

    logic signed [hspd_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [hspd_pkg::MUL_B_W-1:0]  mul_b;
    logic [ERR_W-1:0]                     err_mag;
    logic signed [PROD_W-1:0]             desired;
    logic signed [PROD_W-1:0]             err_raw;
    logic signed [ERR_W-1:0]              err_sat;
    logic signed [ERR_W:0]                err_diff;
    logic signed [DER_W-1:0]              deriv_next;
    logic [hspd_pkg::QUO_W-1:0]           quo;
    logic signed [INC_W-1:0]              inc;
    logic signed [INT_SUM_W-1:0]          int_sum;
    logic signed [INT_SUM_W-1:0]          int_clamped;
    logic signed [INT_W-1:0]              integral_next;
    logic                                 near_setpoint;
    logic                                 sum_pos;
    logic [PROD_W-1:0]                    sum_mag;
    logic [PROD_W-1:0]                    sum_scaled;
    logic [hspd_pkg::LEVEL_W-1:0]         level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            headway_reg <= '0;
            gap_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hspd_pkg::REG_GAIN_P:   gain_p_reg  <= cfg_data;
                hspd_pkg::REG_GAIN_I:   gain_i_reg  <= cfg_data;
                hspd_pkg::REG_GAIN_D:   gain_d_reg  <= cfg_data;
                hspd_pkg::REG_HEADWAY:  headway_reg <= cfg_data[hspd_pkg::HEADWAY_W-1:0];
                hspd_pkg::REG_STANDGAP: gap_reg     <= cfg_data[hspd_pkg::GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Operand selection for the one multiplier.
    assign err_mag = error_reg[ERR_W-1] ? ERR_W'(-error_reg) : ERR_W'(error_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            hspd_pkg::MUL_HEAD:
            begin
                mul_a = hspd_pkg::MUL_A_W'(speed_reg);
                mul_b = hspd_pkg::MUL_B_W'(headway_reg);
            end
            hspd_pkg::MUL_RECIP:
            begin
                mul_a = hspd_pkg::MUL_A_W'(err_mag);
                mul_b = hspd_pkg::MUL_B_W'(hspd_pkg::DIV10_MAGIC);
            end
            hspd_pkg::MUL_PROP:
            begin
                mul_a = hspd_pkg::MUL_A_W'(error_reg);
                mul_b = hspd_pkg::MUL_B_W'(gain_p_reg);
            end
            hspd_pkg::MUL_INTEG:
            begin
                mul_a = hspd_pkg::MUL_A_W'(integral_reg);
                mul_b = hspd_pkg::MUL_B_W'(gain_i_reg);
            end
            hspd_pkg::MUL_DERIV:
            begin
                mul_a = hspd_pkg::MUL_A_W'(deriv_reg);
                mul_b = hspd_pkg::MUL_B_W'(gain_d_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Spacing error from the registered headway product, saturated.
    always_comb
    begin
        desired = (prod_reg >>> FRAC_BITS) + PROD_W'($signed({1'b0, gap_reg}));
        err_raw = PROD_W'($signed({1'b0, dist_reg})) - desired;
        if (err_raw > PROD_W'(hspd_pkg::ERR_MAX))
        begin
            err_sat = hspd_pkg::ERR_MAX;
        end
        else if (err_raw < PROD_W'(hspd_pkg::ERR_MIN))
        begin
            err_sat = hspd_pkg::ERR_MIN;
        end
        else
        begin
            err_sat = err_raw[ERR_W-1:0];
        end
    end

    // Derivative term: difference times ten as two shifted copies.
    always_comb
    begin
        err_diff   = (ERR_W + 1)'(error_reg) - (ERR_W + 1)'(last_error_reg);
        deriv_next = (DER_W'(err_diff) <<< 3) + (DER_W'(err_diff) <<< 1);
    end

    // Integral update from the reciprocal product, which holds |error| / 10.
    always_comb
    begin
        quo = prod_reg[hspd_pkg::DIV10_SHIFT +: hspd_pkg::QUO_W];
        inc = error_reg[ERR_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        int_sum = INT_SUM_W'(integral_reg) + INT_SUM_W'(inc);
        if (int_sum > INT_LIMIT)
        begin
            int_clamped = INT_LIMIT;
        end
        else if (int_sum < -INT_LIMIT)
        begin
            int_clamped = -INT_LIMIT;
        end
        else
        begin
            int_clamped = int_sum;
        end
        near_setpoint = (error_reg > -ERR_HALF) && (error_reg < ERR_HALF);
        integral_next = near_setpoint ? '0 : INT_W'(int_clamped);
    end

    // Output scaling of the PID sum; the sign test is a signed compare.
    always_comb
    begin
        sum_pos    = (pid_sum_reg > PROD_W'(0));
        sum_mag    = sum_pos ? PROD_W'(pid_sum_reg) : PROD_W'(-pid_sum_reg);
        sum_scaled = sum_mag >> OUT_SHIFT;
        level      = (sum_scaled > PROD_W'(hspd_pkg::LEVEL_MAX)) ?
                     hspd_pkg::LEVEL_MAX : sum_scaled[hspd_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg   <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (cmd.int_we)
            begin
                integral_reg <= integral_next;
            end
            if (cmd.deriv_we)
            begin
                last_error_reg <= error_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dist_reg  <= lead_distance;
            speed_reg <= closing_speed;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a * mul_b);
        end
        if (cmd.err_we)
        begin
            error_reg <= err_sat;
        end
        if (cmd.deriv_we)
        begin
            deriv_reg <= deriv_next;
        end
        case (cmd.sum_op)
            hspd_pkg::SUM_LOAD: pid_sum_reg <= prod_reg;
            hspd_pkg::SUM_ADD:  pid_sum_reg <= pid_sum_reg + prod_reg;
            default:
            begin
            end
        endcase
        if (cmd.out_we)
        begin
            throttle_reg <= sum_pos ? level : '0;
            brake_reg    <= sum_pos ? '0 : level;
        end
    end

    assign throttle_level = throttle_reg;
    assign brake_level    = brake_reg;

endmodule

// ===== hdl/headway_spacing_pid_drive_unit.sv =====
// A result beat is valid once the sequencer loads the output register; no new
// item is taken before that. One shared multiplier forms the headway product,
// the divide-by-ten reciprocal and the three gain products in turn.
// The output register holds a finished result while the next item is taken.
// Reset (rst_n, asynchronous, active low) zeroes the gains, headway, gap,
// integral, previous error, sequencer state and the output valid flag.
module headway_spacing_pid_drive_unit
#(
    parameter int FRAC_BITS = hspd_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hspd_pkg::DIST_W-1:0]          lead_distance,
    input  logic signed [hspd_pkg::SPEED_W-1:0]  closing_speed,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hspd_pkg::LEVEL_W-1:0]         throttle_level,
    output logic [hspd_pkg::LEVEL_W-1:0]         brake_level,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hspd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hspd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Command bundle from the sequencer to the datapath.
    hspd_pkg::cmd_t cmd;

    // Configuration writes go straight into their registers, so the port never stalls.
    // Indexes beyond the register list are accepted and ignored.
    assign cfg_ready = 1'b1;

    // The sequencer steps each accepted beat through headway product, error
    // saturation, reciprocal division, integral update and the three gain
    // products, then loads the output register when it is free.
    hspd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the registers, the loop state (integral and previous
    // error) and the single multiplier with its product register.
    hspd_dp
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .lead_distance  (lead_distance),
        .closing_speed  (closing_speed),
        .throttle_level (throttle_level),
        .brake_level    (brake_level)
    );

`ifndef SYNTHESIS
    // Throttle and brake are never commanded together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (throttle_level == '0 || brake_level == '0))
        else $error("throttle and brake both nonzero");

    // Both commands stay within full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (throttle_level <= hspd_pkg::LEVEL_MAX &&
                       brake_level <= hspd_pkg::LEVEL_MAX))
        else $error("output level above full scale");

    // An accepted beat closes the input: in_ready is low right after the accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened right after an accept");
`endif

endmodule
